[rtl/csdt_pkg.sv]
// shared types and constants for the column statistics threshold block
`timescale 1ns / 1ps
package csdt_pkg;

   localparam int DEF_MAX_COLUMNS = 1024;

   // floor(y / 20) = (y * RECIP20) >> RECIP_SHIFT, exact for y below 2**22
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP20 = 20'd838861;

   localparam int VAL_W   = 24;
   localparam int BIT_W   = 5;
   localparam logic [BIT_W-1:0] TOP_BIT = 5'd23;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_OVF   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      F_NONE = 2'd0,
      F_DEV  = 2'd1,
      F_MIN  = 2'd2,
      F_MAX  = 2'd3
   } field_type;

   typedef enum logic {
      SET_TOP = 1'b0,
      SET_SEL = 1'b1
   } set_type;

   typedef enum logic [1:0] {
      K_N95 = 2'd0,
      K_M5  = 2'd1,
      K_M95 = 2'd2
   } kind_type;

   typedef struct packed {
      logic             load;
      logic             clear_set;
      logic             acc_clr;
      logic             rd_en;
      field_type        field;
      set_type          set;
      logic [BIT_W-1:0] bit_idx;
      logic             step;
      logic             prefix_clr;
      logic             k_mul;
      kind_type         kind;
      logic             k_load;
      logic             save_ref;
      logic             save_min;
      logic             save_m;
      logic             out_load;
      status_type       out_status;
   } cmd_type;

   typedef struct packed {
      logic overflow;
      logic rd_last;
      logic acc_zero;
   } stat_type;

endpackage

[rtl/csdt_datapath.sv]
// column store, radix percentile selection and result registers
`timescale 1ns / 1ps
module csdt_datapath #(
   parameter int MAX_COLUMNS = csdt_pkg::DEF_MAX_COLUMNS
) (
   input  logic               clock,
   input  logic               reset,
   input  csdt_pkg::cmd_type  cmd,
   output csdt_pkg::stat_type stat,
   input  logic [15:0]        in_count,
   input  logic [23:0]        in_dev,
   input  logic [13:0]        in_min,
   input  logic [13:0]        in_max,
   input  logic [1:0]         summing_mode,
   output logic [17:0]        out_min,
   output logic [17:0]        out_max,
   output logic [1:0]         out_status
);
   import csdt_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam int YW = CW + 5;
   localparam int PW = YW + RECIP_W;

   logic [67:0] store_mem [MAX_COLUMNS];
   logic [67:0] rdata_ff;
   logic        rvalid_ff;

   logic [15:0]      largest_ff;
   logic [CW-1:0]    loaded_ff;
   logic [CW-1:0]    nequal_ff;
   logic             ovf_ff;
   logic [CW-1:0]    addr_ff;
   logic [CW-1:0]    acc_ff;
   logic [CW-1:0]    k_ff;
   logic [PW-1:0]    prod_ff;
   logic [VAL_W-1:0] prefix_ff;
   logic [VAL_W-1:0] ref_ff;
   logic [13:0]      min_ff;
   logic [CW-1:0]    m_ff;
   logic [17:0]      out_min_ff;
   logic [17:0]      out_max_ff;
   logic [1:0]       out_status_ff;

   logic             full;
   logic [15:0]      r_cnt;
   logic [23:0]      r_dev;
   logic [13:0]      r_min;
   logic [13:0]      r_max;
   logic             member;
   logic [VAL_W-1:0] value;
   logic [VAL_W-1:0] mask_hi;
   logic             hit;
   logic [YW-1:0]    y_in;
   logic [3:0]       fmin;
   logic [3:0]       fmax;

   assign full  = loaded_ff == CW'(MAX_COLUMNS);
   assign r_cnt = rdata_ff[15:0];
   assign r_dev = rdata_ff[39:16];
   assign r_min = rdata_ff[53:40];
   assign r_max = rdata_ff[67:54];

   assign stat.overflow = ovf_ff || full;
   assign stat.rd_last  = addr_ff == (loaded_ff - CW'(1));
   assign stat.acc_zero = acc_ff == '0;

   always_comb begin
      if (cmd.set == SET_TOP) begin
         member = r_cnt == largest_ff;
      end else begin
         member = (20'(r_cnt) * 20'd10 >= 20'(largest_ff) * 20'd9) && (r_dev < ref_ff);
      end
      case (cmd.field)
         F_DEV:   value = r_dev;
         F_MIN:   value = VAL_W'(r_min);
         F_MAX:   value = VAL_W'(r_max);
         default: value = '0;
      endcase
      // bits above the one under test must match the prefix found so far
      mask_hi = ~((VAL_W'(2) << cmd.bit_idx) - VAL_W'(1));
      hit = member && ((cmd.field == F_NONE) ||
                       ((((value ^ prefix_ff) & mask_hi) == '0) && !value[cmd.bit_idx]));
      case (cmd.kind)
         K_N95:   y_in = YW'(nequal_ff - CW'(1)) * YW'(19);
         K_M5:    y_in = YW'(m_ff - CW'(1));
         K_M95:   y_in = YW'(m_ff - CW'(1)) * YW'(19);
         default: y_in = '0;
      endcase
      case (summing_mode)
         2'd0: begin
            fmin = 4'd7;
            fmax = 4'd13;
         end
         2'd1: begin
            fmin = 4'd6;
            fmax = 4'd14;
         end
         default: begin
            fmin = 4'd5;
            fmax = 4'd15;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         store_mem[loaded_ff[AW-1:0]] <= {in_max, in_min, in_dev, in_count};
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_mem[addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff     <= 1'b0;
         largest_ff    <= '0;
         loaded_ff     <= '0;
         nequal_ff     <= '0;
         ovf_ff        <= 1'b0;
         addr_ff       <= '0;
         acc_ff        <= '0;
         out_status_ff <= ST_OK;
      end else begin
         rvalid_ff <= cmd.rd_en;
         if (cmd.clear_set) begin
            largest_ff <= '0;
            loaded_ff  <= '0;
            nequal_ff  <= '0;
            ovf_ff     <= 1'b0;
         end else if (cmd.load) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               loaded_ff <= loaded_ff + CW'(1);
               if (in_count > largest_ff) begin
                  largest_ff <= in_count;
                  nequal_ff  <= CW'(1);
               end else if (in_count == largest_ff) begin
                  nequal_ff <= nequal_ff + CW'(1);
               end
            end
         end
         if (cmd.acc_clr) begin
            acc_ff  <= '0;
            addr_ff <= '0;
         end else begin
            if (cmd.rd_en) begin
               addr_ff <= addr_ff + CW'(1);
            end
            if (rvalid_ff && hit) begin
               acc_ff <= acc_ff + CW'(1);
            end
         end
         if (cmd.out_load) begin
            out_status_ff <= cmd.out_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.k_mul) begin
         prod_ff <= PW'(y_in) * PW'(RECIP20);
      end
      if (cmd.k_load) begin
         k_ff <= CW'(prod_ff >> RECIP_SHIFT);
      end else if (cmd.step && !(k_ff < acc_ff)) begin
         k_ff <= k_ff - acc_ff;
      end
      if (cmd.prefix_clr) begin
         prefix_ff <= '0;
      end else if (cmd.step && !(k_ff < acc_ff)) begin
         prefix_ff[cmd.bit_idx] <= 1'b1;
      end
      if (cmd.save_ref) begin
         ref_ff <= prefix_ff;
      end
      if (cmd.save_min) begin
         min_ff <= prefix_ff[13:0];
      end
      if (cmd.save_m) begin
         m_ff <= acc_ff;
      end
      if (cmd.out_load) begin
         if (cmd.out_status == ST_OK) begin
            out_min_ff <= 18'(min_ff * fmin);
            out_max_ff <= 18'(prefix_ff[13:0] * fmax);
         end else begin
            out_min_ff <= '0;
            out_max_ff <= '0;
         end
      end
   end

   assign out_min    = out_min_ff;
   assign out_max    = out_max_ff;
   assign out_status = out_status_ff;

endmodule

[rtl/csdt_ctrl.sv]
// sequencer for loading, selection passes and result hand-off
`timescale 1ns / 1ps
module csdt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  csdt_pkg::stat_type stat,
   output csdt_pkg::cmd_type  cmd
);
   import csdt_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD, S_KMUL, S_KLOAD, S_PASS, S_DRAIN, S_UPD, S_SAVE, S_FIN
   } state_type;

   typedef enum logic [1:0] {
      PH_DEV, PH_CNT, PH_MIN, PH_MAX
   } phase_type;

   state_type        state_ff;
   phase_type        phase_ff;
   logic [BIT_W-1:0] bit_ff;
   status_type       code_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_LOAD;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.bit_idx    = bit_ff;
      cmd.out_status = code_ff;
      case (phase_ff)
         PH_DEV: begin
            cmd.field = F_DEV;
            cmd.set   = SET_TOP;
            cmd.kind  = K_N95;
         end
         PH_CNT: begin
            cmd.field = F_NONE;
            cmd.set   = SET_SEL;
            cmd.kind  = K_M5;
         end
         PH_MIN: begin
            cmd.field = F_MIN;
            cmd.set   = SET_SEL;
            cmd.kind  = K_M5;
         end
         default: begin
            cmd.field = F_MAX;
            cmd.set   = SET_SEL;
            cmd.kind  = K_M95;
         end
      endcase
      case (state_ff)
         S_LOAD:  cmd.load = req_valid;
         S_KMUL:  cmd.k_mul = 1'b1;
         S_KLOAD: begin
            cmd.k_load     = 1'b1;
            cmd.prefix_clr = 1'b1;
            cmd.acc_clr    = 1'b1;
         end
         S_PASS:  cmd.rd_en = 1'b1;
         S_UPD: begin
            if (phase_ff == PH_CNT) begin
               cmd.save_m = 1'b1;
            end else begin
               cmd.step    = 1'b1;
               cmd.acc_clr = bit_ff != '0;
            end
         end
         S_SAVE: begin
            cmd.save_ref = phase_ff == PH_DEV;
            cmd.save_min = phase_ff == PH_MIN;
            cmd.acc_clr  = phase_ff == PH_DEV;
         end
         S_FIN: begin
            cmd.out_load  = out_free;
            cmd.clear_set = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         phase_ff     <= PH_DEV;
         bit_ff       <= TOP_BIT;
         code_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the result state sets valid itself
         if (rsp_ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_valid && req_last) begin
                  phase_ff <= PH_DEV;
                  if (stat.overflow) begin
                     code_ff  <= ST_OVF;
                     state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_KMUL;
                  end
               end
            end
            S_KMUL: state_ff <= S_KLOAD;
            S_KLOAD: begin
               bit_ff   <= TOP_BIT;
               state_ff <= S_PASS;
            end
            S_PASS: begin
               if (stat.rd_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_UPD;
            S_UPD: begin
               if (phase_ff == PH_CNT) begin
                  if (stat.acc_zero) begin
                     code_ff  <= ST_EMPTY;
                     state_ff <= S_FIN;
                  end else begin
                     phase_ff <= PH_MIN;
                     state_ff <= S_KMUL;
                  end
               end else if (bit_ff != '0) begin
                  bit_ff   <= bit_ff - BIT_W'(1);
                  state_ff <= S_PASS;
               end else begin
                  state_ff <= S_SAVE;
               end
            end
            S_SAVE: begin
               case (phase_ff)
                  PH_DEV: begin
                     phase_ff <= PH_CNT;
                     state_ff <= S_PASS;
                  end
                  PH_MIN: begin
                     phase_ff <= PH_MAX;
                     state_ff <= S_KMUL;
                  end
                  default: begin
                     code_ff  <= ST_OK;
                     state_ff <= S_FIN;
                  end
               endcase
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

endmodule

[rtl/column_stats_dn_threshold.sv]
// Column statistics DN threshold finder. Columns load at one request per cycle
// into a single-port column memory. The request flagged tlast starts the
// selection: three radix percentile searches of 24 passes each plus one count
// pass, every pass reading all L stored columns through the one memory read
// port. The result is then offered on the output, held back while the previous
// result is still waiting there. No request is taken during that time; a result
// waiting on the output does not hold up loading of the next set. The memory
// needs no clearing after reset.
`timescale 1ns / 1ps
module column_stats_dn_threshold #(
   parameter int MAX_COLUMNS = csdt_pkg::DEF_MAX_COLUMNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // valid_count[15:0], column_std_dev[39:16], column_minimum[53:40],
   // column_maximum[67:54], zero fill above
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // min_dn_tenths[17:0], max_dn_tenths[35:18], zero fill above
   output logic [39:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import csdt_pkg::*;

   logic [1:0]  summing_mode_ff;
   logic [1:0]  summing_mode_in;
   cmd_type     cmd;
   stat_type    stat;
   logic [17:0] out_min;
   logic [17:0] out_max;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {30'd0, summing_mode_ff} : 32'd0;

   always_comb begin
      summing_mode_in = summing_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0)) begin
         summing_mode_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         summing_mode_ff <= 2'd0;
      end else begin
         summing_mode_ff <= summing_mode_in;
      end
   end

   csdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csdt_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_count     (req_tdata[15:0]),
      .in_dev       (req_tdata[39:16]),
      .in_min       (req_tdata[53:40]),
      .in_max       (req_tdata[67:54]),
      .summing_mode (summing_mode_ff),
      .out_min      (out_min),
      .out_max      (out_max),
      .out_status   (rsp_tuser)
   );

   assign rsp_tdata = {4'd0, out_max, out_min};

endmodule

[rtl/csdt_checker.sv]
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
module csdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import csdt_pkg::*;

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_EMPTY ||
                      rsp_tuser == ST_OVF))
      else $error("undefined status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == 40'd0)
      else $error("thresholds not zero on error status");

endmodule

bind column_stats_dn_threshold csdt_checker u_csdt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/tb_column_stats_dn_threshold.sv]
// self-checking testbench for the column statistics DN threshold finder
`timescale 1ns / 1ps
module tb_column_stats_dn_threshold;
   import csdt_pkg::*;

   localparam int COLS      = DEF_MAX_COLUMNS;
   localparam int LIMIT     = 3000000;
   localparam int HOLD_LEN  = 4000;
   localparam logic [2:0] ADDR_MODE   = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;

   typedef struct {
      logic [17:0] min_tenths;
      logic [17:0] max_tenths;
      status_type  status;
   } threshold_type;

   class threshold_scoreboard;
      int unsigned counts[$], devs[$], mins[$], maxs[$];
      int unsigned largest;
      bit          overflow;
      logic [1:0]  mode;
      threshold_type pending[$];
      int          mismatches;

      function new();
         largest = 0; overflow = 0; mode = 0; mismatches = 0;
      endfunction

      // sorts a copy ascending and returns entry k
      function int unsigned pick_sorted(int unsigned vals[$], int unsigned k);
         int unsigned v;
         int j;
         for (int i = 1; i < vals.size(); i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > v) begin
               vals[j] = vals[j-1];
               j--;
            end
            vals[j] = v;
         end
         if (k >= vals.size()) k = vals.size() - 1;
         return vals[k];
      endfunction

      function void note_column(logic [15:0] cnt, logic [23:0] dev, logic [13:0] mn,
                                logic [13:0] mx, bit last);
         threshold_type t;
         int unsigned tops[$], sel_min[$], sel_max[$];
         int unsigned ref_dev, lo, hi, fmin, fmax;
         if (counts.size() < COLS) begin
            counts.insert(counts.size(), 32'(cnt));
            devs.insert(devs.size(), 32'(dev));
            mins.insert(mins.size(), 32'(mn));
            maxs.insert(maxs.size(), 32'(mx));
            if (cnt > largest) largest = cnt;
         end else begin
            overflow = 1;
         end
         if (!last) return;
         t.min_tenths = 0; t.max_tenths = 0;
         if (overflow || counts.size() == 0) begin
            t.status = ST_OVF;
         end else begin
            foreach (counts[i])
               if (counts[i] == largest) tops.insert(tops.size(), devs[i]);
            ref_dev = pick_sorted(tops, ((tops.size() - 1) * 95) / 100);
            foreach (counts[i])
               if (counts[i] * 10 >= largest * 9 && devs[i] < ref_dev) begin
                  sel_min.insert(sel_min.size(), mins[i]);
                  sel_max.insert(sel_max.size(), maxs[i]);
               end
            if (sel_min.size() == 0) begin
               t.status = ST_EMPTY;
            end else begin
               lo = pick_sorted(sel_min, ((sel_min.size() - 1) * 5) / 100);
               hi = pick_sorted(sel_max, ((sel_max.size() - 1) * 95) / 100);
               case (mode)
                  2'd0: begin fmin = 7; fmax = 13; end
                  2'd1: begin fmin = 6; fmax = 14; end
                  default: begin fmin = 5; fmax = 15; end
               endcase
               t.min_tenths = 18'(lo * fmin);
               t.max_tenths = 18'(hi * fmax);
               t.status     = ST_OK;
            end
         end
         pending.insert(pending.size(), t);
         counts.delete(); devs.delete(); mins.delete(); maxs.delete();
         largest = 0; overflow = 0;
      endfunction

      function void check_result(logic [17:0] mn, logic [17:0] mx, logic [1:0] st);
         threshold_type t;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: min %0d max %0d status %0d", mn, mx, st);
            return;
         end
         t = pending.pop_front();
         if (mn !== t.min_tenths || mx !== t.max_tenths || st !== t.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected min %0d max %0d status %0d, got %0d %0d %0d",
                        t.min_tenths, t.max_tenths, t.status, mn, mx, st);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   threshold_scoreboard sb = new();
   bit no_idle = 0;
   bit hold_req = 0;
   int hold_left = 0;
   bit held_once = 0;
   int cycles = 0;

   column_stats_dn_threshold dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver side: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (hold_req && !held_once && hold_left == 0) begin
         hold_left <= HOLD_LEN;
         held_once <= 1;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 32);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[17:0], rsp_tdata[35:18], rsp_tuser);

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (addr == ADDR_MODE) sb.mode = data[1:0];
   endtask

   task automatic send_column(logic [15:0] cnt, logic [23:0] dev, logic [13:0] mn,
                              logic [13:0] mx, bit last);
      req_tvalid <= 1;
      req_tdata  <= {4'b0, mx, mn, dev, cnt};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_column(cnt, dev, mn, mx, last);
      while (!no_idle && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one set; counts cluster near a base so the 90 percent cut is exercised
   task automatic random_set(int len);
      int unsigned base;
      logic [15:0] cnt;
      logic [23:0] dev;
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(10, 2000);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 4))
            0: cnt = 16'(base);
            1: cnt = 16'($urandom_range(0, 65535));
            default: cnt = 16'(base - $urandom_range(0, base / 6));
         endcase
         dev = ($urandom_range(0, 5) == 0) ? 24'd1000 : 24'($urandom_range(0, 24'hFFFFFF));
         send_column(cnt, dev, 14'($urandom_range(0, 16383)),
                     14'($urandom_range(0, 16383)), i == len - 1);
      end
   endtask

   initial begin
      int sent;
      int len;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: single column gives an empty selection
      send_column(16'd100, 24'd50, 14'd10, 14'd20, 1);
      // extremes of every field
      send_column(16'hFFFF, 24'hFFFFFF, 14'h3FFF, 14'h3FFF, 0);
      send_column(16'hFFFF, 24'd0, 14'h3FFF, 14'h3FFF, 0);
      send_column(16'd0, 24'd0, 14'd0, 14'd0, 1);
      drain();
      // 90 percent boundary: 90 kept, 89 dropped
      for (int m = 0; m < 4; m++) begin
         csr_write(ADDR_MODE, m);
         send_column(16'd100, 24'd900, 14'd5, 14'd9000, 0);
         send_column(16'd100, 24'd100, 14'd0, 14'd16383, 0);
         send_column(16'd90, 24'd10, 14'd3000, 14'd12000, 0);
         send_column(16'd89, 24'd5, 14'd1, 14'd16000, 1);
         drain();
      end
      csr_write(ADDR_UNUSED, 32'hFFFF_FFFF);
      send_column(16'd7, 24'd9, 14'd100, 14'd200, 0);
      send_column(16'd7, 24'd1, 14'd300, 14'd400, 1);
      drain();
      csr_write(ADDR_MODE, 2);

      // random sets; receiver holds off while small sets keep coming
      sent = 0;
      while (sent < 430) begin
         if (sent > 100 && !hold_req) hold_req = 1;
         no_idle = (sent >= 250 && sent < 330);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
         random_set(len);
         sent += len;
         if ($urandom_range(0, 7) == 0) begin
            drain();
            csr_write(ADDR_MODE, $urandom_range(0, 3));
         end
      end
      no_idle = 0;
      drain();
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
